>>> rtl/bfh_pkg.sv
// Package for the brute-force hull point counter.
// Sizes, payload types, sequencer states and inter-module structs.
// No dependencies; every other file in rtl/ uses it.
package bfh_pkg;

   // Sizing
   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int HULL_W     = 7;
   localparam int POINT_W    = 2 * COORD_BITS;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int CROSS_W    = PROD_W + 1;
   // smallest set that has a triangle plus one more point
   localparam int MIN_SWEEP  = 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [CROSS_W-1:0]    cross_type;
   typedef logic [IDX_W-1:0]             idx_type;
   typedef logic [CNT_W-1:0]             cnt_type;
   typedef logic [HULL_W-1:0]            hull_type;
   typedef logic [POINT_W-1:0]           point_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_P_READ,
      ST_P_CAP,
      ST_TRI,
      ST_RD_B,
      ST_RD_C,
      ST_CAP_C,
      ST_MUL_A,
      ST_MUL_B,
      ST_ACC,
      ST_DECIDE,
      ST_NEXT_P,
      ST_RESULT
   } state_type;

   // Triangle side under test
   typedef enum logic [1:0] {
      SIDE_AB,
      SIDE_BC,
      SIDE_CA
   } side_type;

   // Point store access
   typedef struct packed {
      logic      wr_en;
      idx_type   wr_addr;
      point_type wr_data;
      idx_type   rd_addr;
   } store_req_type;

   // Cross-product unit control
   typedef struct packed {
      logic     cap_p;
      logic     cap_a;
      logic     cap_b;
      logic     cap_c;
      logic     mul_a;
      logic     mul_b;
      logic     acc;
      side_type side_sel;
   } cross_ctrl_type;

   // Finished result toward the output register
   typedef struct packed {
      logic     load;
      hull_type hull_count;
      logic     overflow;
   } result_type;

endpackage

>>> rtl/bfh_if.sv
// Channel interfaces for the hull point counter: point input and count result.
// Depends on bfh_pkg.
interface bfh_req_if;
   logic                     valid;
   logic                     ready;
   bfh_pkg::coord_type       point_x;
   bfh_pkg::coord_type       point_y;
   logic                     last_point;

   modport source (output valid, output point_x, output point_y, output last_point,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input last_point,
                   output ready);
endinterface

interface bfh_rsp_if;
   logic                     valid;
   logic                     ready;
   bfh_pkg::hull_type        hull_count;
   logic                     overflow;

   modport source (output valid, output hull_count, output overflow, input ready);
   modport sink   (input valid, input hull_count, input overflow, output ready);
endinterface

>>> rtl/bfh_store.sv
// Point store: one write port, one read port, registered read data.
// Depends on bfh_pkg. Contents are undefined until written.
module bfh_store (
   input  logic                   clock,
   input  bfh_pkg::store_req_type req,
   output bfh_pkg::point_type     rd_data
);

   bfh_pkg::point_type mem [bfh_pkg::MAX_POINTS];
   bfh_pkg::point_type rd_data_ff;

   // Writes happen only while loading, reads only while sweeping: no overlap
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      rd_data_ff <= mem[req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bfh_cross.sv
// Orientation test unit: holds test point and triangle corners, one shared
// multiplier, sign flags over the three sides. Depends on bfh_pkg.
module bfh_cross (
   input  logic                    clock,
   input  bfh_pkg::cross_ctrl_type ctrl,
   input  bfh_pkg::point_type      rd_data,
   output logic                    in_tri
);

   bfh_pkg::coord_type rd_x, rd_y;
   bfh_pkg::coord_type px_ff, py_ff, ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   bfh_pkg::coord_type sx, sy, ex, ey;
   bfh_pkg::diff_type  dx, dy, qx, qy, op1, op2;
   bfh_pkg::prod_type  prod_in, prod_a_ff, prod_b_ff;
   bfh_pkg::cross_type cross_val;
   logic               neg_in, pos_in, neg_ff, pos_ff;

   assign rd_x = bfh_pkg::coord_type'(rd_data[bfh_pkg::COORD_BITS-1:0]);
   assign rd_y = bfh_pkg::coord_type'(rd_data[bfh_pkg::POINT_W-1:bfh_pkg::COORD_BITS]);

   // Side start/end corners
   always_comb begin
      case (ctrl.side_sel)
         bfh_pkg::SIDE_AB: begin
            sx = ax_ff; sy = ay_ff; ex = bx_ff; ey = by_ff;
         end
         bfh_pkg::SIDE_BC: begin
            sx = bx_ff; sy = by_ff; ex = cx_ff; ey = cy_ff;
         end
         default: begin
            sx = cx_ff; sy = cy_ff; ex = ax_ff; ey = ay_ff;
         end
      endcase
   end

   // Edge and point vectors, one product per cycle
   always_comb begin
      dx      = bfh_pkg::diff_type'(ex) - bfh_pkg::diff_type'(sx);
      dy      = bfh_pkg::diff_type'(ey) - bfh_pkg::diff_type'(sy);
      qx      = bfh_pkg::diff_type'(px_ff) - bfh_pkg::diff_type'(sx);
      qy      = bfh_pkg::diff_type'(py_ff) - bfh_pkg::diff_type'(sy);
      op1     = ctrl.mul_b ? dy : dx;
      op2     = ctrl.mul_b ? qx : qy;
      prod_in = bfh_pkg::prod_type'(op1) * bfh_pkg::prod_type'(op2);
   end

   // Cross product sign collection
   always_comb begin
      cross_val = bfh_pkg::cross_type'(prod_a_ff) - bfh_pkg::cross_type'(prod_b_ff);
      neg_in    = neg_ff;
      pos_in    = pos_ff;
      if (ctrl.cap_c) begin
         neg_in = 1'b0;
         pos_in = 1'b0;
      end else if (ctrl.acc) begin
         neg_in = neg_ff | (cross_val < 0);
         pos_in = pos_ff | (cross_val > 0);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.cap_p) begin
         px_ff <= rd_x;
         py_ff <= rd_y;
      end
      if (ctrl.cap_a) begin
         ax_ff <= rd_x;
         ay_ff <= rd_y;
      end
      if (ctrl.cap_b) begin
         bx_ff <= rd_x;
         by_ff <= rd_y;
      end
      if (ctrl.cap_c) begin
         cx_ff <= rd_x;
         cy_ff <= rd_y;
      end
      if (ctrl.mul_a) begin
         prod_a_ff <= prod_in;
      end
      if (ctrl.mul_b) begin
         prod_b_ff <= prod_in;
      end
      neg_ff <= neg_in;
      pos_ff <= pos_in;
   end

   // Boundary and collinear count as inside: only mixed strict signs are outside
   assign in_tri = !(neg_ff && pos_ff);

endmodule

>>> rtl/bfh_seq.sv
// Sequencer: loads points into the store, walks test point and triangle
// indexes, counts points never found inside. Depends on bfh_pkg.
module bfh_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bfh_pkg::coord_type      req_x,
   input  bfh_pkg::coord_type      req_y,
   input  logic                    req_last,
   input  logic                    out_free,
   input  logic                    in_tri,
   output bfh_pkg::store_req_type  store_req,
   output bfh_pkg::cross_ctrl_type cross_ctrl,
   output bfh_pkg::result_type     result
);

   bfh_pkg::state_type state_ff, state_in;
   bfh_pkg::cnt_type   cnt_ff, cnt_in, n_ff, n_in, hull_ff, hull_in, cnt_next;
   bfh_pkg::cnt_type   n_m1, n_m2, n_m3;
   bfh_pkg::idx_type   p_ff, p_in, i_ff, i_in, j_ff, j_in, k_ff, k_in;
   bfh_pkg::side_type  side_ff, side_in;
   logic               ovf_ff, ovf_in, flag_ff, flag_in;
   logic               accept, room, short_set, p_hit, tri_last, k_end, j_end, p_last;
   logic [bfh_pkg::CNT_W:0]                    cnt_wide;
   logic [bfh_pkg::HULL_W+bfh_pkg::CNT_W-1:0]  hull_wide;

   // Status terms
   always_comb begin
      accept    = req_valid && req_ready;
      room      = cnt_ff < bfh_pkg::cnt_type'(bfh_pkg::MAX_POINTS);
      cnt_next  = room ? cnt_ff + bfh_pkg::cnt_type'(1) : cnt_ff;
      cnt_wide  = {1'b0, cnt_next};
      short_set = cnt_wide < (bfh_pkg::CNT_W + 1)'(bfh_pkg::MIN_SWEEP);
      n_m1      = n_ff - bfh_pkg::cnt_type'(1);
      n_m2      = n_ff - bfh_pkg::cnt_type'(2);
      n_m3      = n_ff - bfh_pkg::cnt_type'(3);
      p_hit     = (p_ff == i_ff) || (p_ff == j_ff) || (p_ff == k_ff);
      tri_last  = bfh_pkg::cnt_type'(i_ff) == n_m3;
      k_end     = bfh_pkg::cnt_type'(k_ff) == n_m1;
      j_end     = bfh_pkg::cnt_type'(j_ff) == n_m2;
      p_last    = bfh_pkg::cnt_type'(p_ff) == n_m1;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfh_pkg::ST_LOAD: begin
            if (accept && req_last) begin
               state_in = short_set ? bfh_pkg::ST_RESULT : bfh_pkg::ST_P_READ;
            end
         end
         bfh_pkg::ST_P_READ: state_in = bfh_pkg::ST_P_CAP;
         bfh_pkg::ST_P_CAP:  state_in = bfh_pkg::ST_TRI;
         bfh_pkg::ST_TRI: begin
            if (!p_hit) begin
               state_in = bfh_pkg::ST_RD_B;
            end else if (tri_last) begin
               state_in = bfh_pkg::ST_NEXT_P;
            end
         end
         bfh_pkg::ST_RD_B:   state_in = bfh_pkg::ST_RD_C;
         bfh_pkg::ST_RD_C:   state_in = bfh_pkg::ST_CAP_C;
         bfh_pkg::ST_CAP_C:  state_in = bfh_pkg::ST_MUL_A;
         bfh_pkg::ST_MUL_A:  state_in = bfh_pkg::ST_MUL_B;
         bfh_pkg::ST_MUL_B:  state_in = bfh_pkg::ST_ACC;
         bfh_pkg::ST_ACC: begin
            state_in = (side_ff == bfh_pkg::SIDE_CA) ? bfh_pkg::ST_DECIDE : bfh_pkg::ST_MUL_A;
         end
         bfh_pkg::ST_DECIDE: begin
            state_in = (in_tri || tri_last) ? bfh_pkg::ST_NEXT_P : bfh_pkg::ST_TRI;
         end
         bfh_pkg::ST_NEXT_P: begin
            state_in = p_last ? bfh_pkg::ST_RESULT : bfh_pkg::ST_P_READ;
         end
         bfh_pkg::ST_RESULT: begin
            if (out_free) begin
               state_in = bfh_pkg::ST_LOAD;
            end
         end
         default: state_in = bfh_pkg::ST_LOAD;
      endcase
   end

   // Counters and flags
   always_comb begin
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      n_in    = n_ff;
      hull_in = hull_ff;
      p_in    = p_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      k_in    = k_ff;
      side_in = side_ff;
      flag_in = flag_ff;
      case (state_ff)
         bfh_pkg::ST_LOAD: begin
            if (accept) begin
               cnt_in = cnt_next;
               ovf_in = ovf_ff || !room;
               if (req_last) begin
                  n_in    = cnt_next;
                  hull_in = short_set ? cnt_next : '0;
                  p_in    = '0;
               end
            end
         end
         bfh_pkg::ST_P_CAP: begin
            i_in    = bfh_pkg::idx_type'(0);
            j_in    = bfh_pkg::idx_type'(1);
            k_in    = bfh_pkg::idx_type'(2);
            flag_in = 1'b0;
         end
         bfh_pkg::ST_CAP_C: side_in = bfh_pkg::SIDE_AB;
         bfh_pkg::ST_ACC: begin
            side_in = (side_ff == bfh_pkg::SIDE_AB) ? bfh_pkg::SIDE_BC : bfh_pkg::SIDE_CA;
         end
         bfh_pkg::ST_DECIDE: flag_in = in_tri;
         bfh_pkg::ST_NEXT_P: begin
            if (!flag_ff) begin
               hull_in = hull_ff + bfh_pkg::cnt_type'(1);
            end
            p_in = p_ff + bfh_pkg::idx_type'(1);
         end
         bfh_pkg::ST_RESULT: begin
            if (out_free) begin
               cnt_in = '0;
               ovf_in = 1'b0;
            end
         end
         default: ;
      endcase
      // Step to the next triangle i < j < k
      if (((state_ff == bfh_pkg::ST_TRI) && p_hit && !tri_last) ||
          ((state_ff == bfh_pkg::ST_DECIDE) && !in_tri && !tri_last)) begin
         if (!k_end) begin
            k_in = k_ff + bfh_pkg::idx_type'(1);
         end else if (!j_end) begin
            j_in = j_ff + bfh_pkg::idx_type'(1);
            k_in = j_ff + bfh_pkg::idx_type'(2);
         end else begin
            i_in = i_ff + bfh_pkg::idx_type'(1);
            j_in = i_ff + bfh_pkg::idx_type'(2);
            k_in = i_ff + bfh_pkg::idx_type'(3);
         end
      end
   end

   // Outputs
   always_comb begin
      req_ready          = state_ff == bfh_pkg::ST_LOAD;
      store_req.wr_en    = accept && room;
      store_req.wr_addr  = cnt_ff[bfh_pkg::IDX_W-1:0];
      store_req.wr_data  = {req_y, req_x};
      case (state_ff)
         bfh_pkg::ST_TRI:  store_req.rd_addr = i_ff;
         bfh_pkg::ST_RD_B: store_req.rd_addr = j_ff;
         bfh_pkg::ST_RD_C: store_req.rd_addr = k_ff;
         default:          store_req.rd_addr = p_ff;
      endcase
      cross_ctrl.cap_p    = state_ff == bfh_pkg::ST_P_CAP;
      cross_ctrl.cap_a    = state_ff == bfh_pkg::ST_RD_B;
      cross_ctrl.cap_b    = state_ff == bfh_pkg::ST_RD_C;
      cross_ctrl.cap_c    = state_ff == bfh_pkg::ST_CAP_C;
      cross_ctrl.mul_a    = state_ff == bfh_pkg::ST_MUL_A;
      cross_ctrl.mul_b    = state_ff == bfh_pkg::ST_MUL_B;
      cross_ctrl.acc      = state_ff == bfh_pkg::ST_ACC;
      cross_ctrl.side_sel = side_ff;
      hull_wide           = {{bfh_pkg::HULL_W{1'b0}}, hull_ff};
      result.load         = (state_ff == bfh_pkg::ST_RESULT) && out_free;
      result.hull_count   = hull_wide[bfh_pkg::HULL_W-1:0];
      result.overflow     = ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfh_pkg::ST_LOAD;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         n_ff     <= '0;
         hull_ff  <= '0;
         p_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         side_ff  <= bfh_pkg::SIDE_AB;
         flag_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         n_ff     <= n_in;
         hull_ff  <= hull_in;
         p_ff     <= p_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         side_ff  <= side_in;
         flag_ff  <= flag_in;
      end
   end

   // Triangle indexes stay ordered and inside the set
   a_tri_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfh_pkg::ST_TRI) |->
         (i_ff < j_ff) && (j_ff < k_ff) && (bfh_pkg::cnt_type'(k_ff) < n_ff))
      else $error("triangle indexes out of order or range");

   // A sweep only runs on a set large enough to hold a triangle and a point
   a_sweep_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfh_pkg::ST_P_READ) |->
         (bfh_pkg::cnt_type'(p_ff) < n_ff) &&
         ({1'b0, n_ff} >= (bfh_pkg::CNT_W + 1)'(bfh_pkg::MIN_SWEEP)))
      else $error("sweep point index or set size invalid");

   // Hull count never exceeds the number of stored points
   a_hull_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfh_pkg::ST_RESULT) |-> (hull_ff <= n_ff))
      else $error("hull count above point count");

   // Handing over a result starts a fresh set
   a_set_restart: assert property (@(posedge clock) disable iff (reset)
      result.load |=> (cnt_ff == '0) && !ovf_ff && (state_ff == bfh_pkg::ST_LOAD))
      else $error("set state not cleared after result");

endmodule

>>> rtl/brute_force_hull_point_count_core.sv
// Brute-force hull point counter, top level. Points load at one transfer per cycle
// while the sequencer is in its load state. On the last point, n < 4: the result
// register loads once it is free. Otherwise the sweep is paced by the single store
// read port and the one shared multiplier.
// Reset is synchronous: clears control and the result valid flag; store not cleared.
module brute_force_hull_point_count_core (
   input  logic      clock,
   input  logic      reset,
   bfh_req_if.sink   req_chan,
   bfh_rsp_if.source rsp_chan
);

   bfh_pkg::store_req_type  store_req;
   bfh_pkg::cross_ctrl_type cross_ctrl;
   bfh_pkg::result_type     result;
   bfh_pkg::point_type      rd_data;
   bfh_pkg::hull_type       rsp_hull_ff;
   logic                    rsp_valid_ff, rsp_ovf_ff, out_free, in_tri;

   bfh_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_x      (req_chan.point_x),
      .req_y      (req_chan.point_y),
      .req_last   (req_chan.last_point),
      .out_free   (out_free),
      .in_tri     (in_tri),
      .store_req  (store_req),
      .cross_ctrl (cross_ctrl),
      .result     (result)
   );

   bfh_store u_store (
      .clock   (clock),
      .req     (store_req),
      .rd_data (rd_data)
   );

   bfh_cross u_cross (
      .clock   (clock),
      .ctrl    (cross_ctrl),
      .rd_data (rd_data),
      .in_tri  (in_tri)
   );

   // Output register: free when empty or its transfer completes this cycle
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= result.load;
      end
   end

   always_ff @(posedge clock) begin
      if (result.load) begin
         rsp_hull_ff <= result.hull_count;
         rsp_ovf_ff  <= result.overflow;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hull_count = rsp_hull_ff;
   assign rsp_chan.overflow   = rsp_ovf_ff;

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Testbench for brute_force_hull_point_count_core: streams point sets and checks
// each hull count and overflow flag against a triangle-containment predictor.
// Depends on rtl/bfh_pkg.sv, rtl/bfh_if.sv and the core RTL.
module tb;

   typedef enum int {
      CS_FULL,
      CS_GRID,
      CS_EDGE,
      CS_MID
   } coord_style_type;

   // one queued point, or a marker that holds the sender until results drain
   typedef struct {
      bfh_pkg::coord_type x;
      bfh_pkg::coord_type y;
      logic               last;
      bit                 pause;
   } point_item_type;

   typedef struct {
      bfh_pkg::hull_type count;
      logic              ovf;
   } hull_result_type;

   localparam int POINT_GOAL   = 750;
   localparam int MAX_GAP      = 14;
   localparam int HOLD_AFTER   = 2;
   localparam int LONG_HOLD    = 600;
   localparam int DRAIN_CYCLES = 2000;

   logic clock;
   logic reset;

   bfh_req_if req_if ();
   bfh_rsp_if rsp_if ();

   brute_force_hull_point_count_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   point_item_type  point_queue[$];
   hull_result_type hull_expect[$];
   hull_result_type want_result;
   point_item_type  next_item;

   // predictor copy of the current set
   int set_x[bfh_pkg::MAX_POINTS];
   int set_y[bfh_pkg::MAX_POINTS];
   int set_len;
   bit set_dropped;

   int   point_total;
   int   errors;
   logic req_taken;
   logic rsp_taken;
   int   send_wait;
   int   recv_wait;
   int   hold_left;
   int   results_seen;
   bit   send_idle;
   bit   recv_idle;

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // cross product (B-A) x (P-A), exact
   function automatic longint turn(int a, int b, int p);
      return longint'(set_x[b] - set_x[a]) * longint'(set_y[p] - set_y[a])
           - longint'(set_y[b] - set_y[a]) * longint'(set_x[p] - set_x[a]);
   endfunction

   // inside or on the boundary: the three turns never take both strict signs
   function automatic bit covered(int a, int b, int c, int p);
      longint t1;
      longint t2;
      longint t3;
      bit     neg;
      bit     pos;
      t1  = turn(a, b, p);
      t2  = turn(b, c, p);
      t3  = turn(c, a, p);
      neg = (t1 < 0) || (t2 < 0) || (t3 < 0);
      pos = (t1 > 0) || (t2 > 0) || (t3 > 0);
      return !(neg && pos);
   endfunction

   function automatic bfh_pkg::hull_type count_hull();
      int i;
      int j;
      int k;
      int p;
      int hull;
      bit found;
      hull = 0;
      for (p = 0; p < set_len; p++) begin
         found = 1'b0;
         for (i = 0; i < set_len && !found; i++)
            for (j = i + 1; j < set_len && !found; j++)
               for (k = j + 1; k < set_len && !found; k++)
                  if (p != i && p != j && p != k && covered(i, j, k, p))
                     found = 1'b1;
         if (!found)
            hull++;
      end
      return bfh_pkg::hull_type'(hull);
   endfunction

   // store one accepted point; the last one of a set yields the expected result
   task automatic absorb_point(bfh_pkg::coord_type x, bfh_pkg::coord_type y, logic last);
      hull_result_type res;
      if (set_len < bfh_pkg::MAX_POINTS) begin
         set_x[set_len] = x;
         set_y[set_len] = y;
         set_len++;
      end else begin
         set_dropped = 1'b1;
      end
      if (last) begin
         res.count = count_hull();
         res.ovf   = set_dropped;
         hull_expect.push_back(res);
         set_len     = 0;
         set_dropped = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------

   task automatic add_point(int x, int y, logic last);
      point_item_type it;
      it.x     = bfh_pkg::coord_type'(x);
      it.y     = bfh_pkg::coord_type'(y);
      it.last  = last;
      it.pause = 1'b0;
      point_queue.push_back(it);
      point_total++;
   endtask

   task automatic add_pause();
      point_item_type it;
      it = '{x: '0, y: '0, last: 1'b0, pause: 1'b1};
      point_queue.push_back(it);
   endtask

   function automatic int pick_coord(coord_style_type s);
      case (s)
         CS_FULL: return int'(bfh_pkg::coord_type'($urandom()));
         CS_GRID: return int'($urandom_range(0, 8)) - 4;
         CS_EDGE: begin
            case ($urandom_range(0, 3))
               0:       return -32768;
               1:       return 32767;
               2:       return 0;
               default: return -1;
            endcase
         end
         default: return int'($urandom_range(0, 400)) - 200;
      endcase
   endfunction

   // random set, with some points repeating earlier ones
   task automatic add_random_set(int n, coord_style_type s);
      int k;
      int pick;
      int x;
      int y;
      int xs[$];
      int ys[$];
      for (k = 0; k < n; k++) begin
         if (k > 0 && $urandom_range(0, 7) == 0) begin
            pick = $urandom_range(0, k - 1);
            x    = xs[pick];
            y    = ys[pick];
         end else begin
            x = pick_coord(s);
            y = pick_coord(s);
         end
         xs.push_back(x);
         ys.push_back(y);
         add_point(x, y, k == n - 1);
      end
   endtask

   // identical or collinear points: every point falls inside early, so a
   // full store sweeps fast
   task automatic add_flat_set(int n);
      int x0;
      int y0;
      int dx;
      int dy;
      int k;
      x0 = int'($urandom_range(0, 2000)) - 1000;
      y0 = int'($urandom_range(0, 2000)) - 1000;
      if ($urandom_range(0, 1) == 0) begin
         dx = 0;
         dy = 0;
      end else begin
         dx = int'($urandom_range(0, 6)) - 3;
         dy = int'($urandom_range(0, 6)) - 3;
      end
      for (k = 0; k < n; k++)
         add_point(x0 + k * dx, y0 + k * dy, k == n - 1);
   endtask

   // ---------------------------------------------------------------
   // Clock and initial input values
   // ---------------------------------------------------------------
   initial begin
      clock             = 1'b0;
      req_if.valid      = 1'b0;
      req_if.point_x    = '0;
      req_if.point_y    = '0;
      req_if.last_point = 1'b0;
      rsp_if.ready      = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Driver: offers queued points at the falling edge
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_wait = 0;
         send_idle = 1'b0;
      end else begin
         if (req_taken) begin
            if ($urandom_range(0, 31) == 0)
               send_idle = !send_idle;
            send_wait = send_idle ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (!req_if.valid || req_taken) begin
            if (send_wait > 0) begin
               send_wait--;
               req_if.valid <= 1'b0;
            end else if (point_queue.size() > 0 && !point_queue[0].pause) begin
               next_item = point_queue.pop_front();
               req_if.point_x    <= next_item.x;
               req_if.point_y    <= next_item.y;
               req_if.last_point <= next_item.last;
               req_if.valid      <= 1'b1;
            end else begin
               // pause marker: hold until every expected count has come back
               if (point_queue.size() > 0 && hull_expect.size() == 0)
                  void'(point_queue.pop_front());
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Receiver: random stalls once a result shows, one long hold-off
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_wait    = 0;
         recv_idle    = 1'b1;
         hold_left    = 0;
         results_seen = 0;
      end else begin
         if (rsp_taken) begin
            results_seen++;
            if ($urandom_range(0, 31) == 0)
               recv_idle = !recv_idle;
            recv_wait = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (results_seen == HOLD_AFTER)
               hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_if.valid && recv_wait > 0) begin
            recv_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: checks result transfers, feeds point transfers to the predictor
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         rsp_taken <= rsp_if.valid && rsp_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (hull_expect.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual count %0d overflow %0b",
                        $time, rsp_if.hull_count, rsp_if.overflow);
               errors++;
            end else begin
               want_result = hull_expect.pop_front();
               if (rsp_if.hull_count !== want_result.count) begin
                  $display("%0t: hull_count expected %0d actual %0d",
                           $time, want_result.count, rsp_if.hull_count);
                  errors++;
               end
               if (rsp_if.overflow !== want_result.ovf) begin
                  $display("%0t: overflow expected %0b actual %0b",
                           $time, want_result.ovf, rsp_if.overflow);
                  errors++;
               end
            end
         end
         if (req_if.valid && req_if.ready)
            absorb_point(req_if.point_x, req_if.point_y, req_if.last_point);
      end
   end

   // ---------------------------------------------------------------
   // Sequence: reset, stimulus, drain, verdict
   // ---------------------------------------------------------------
   initial begin
      int set_no;
      int n;
      reset       = 1'b1;
      errors      = 0;
      point_total = 0;
      set_len     = 0;
      set_dropped = 1'b0;

      // sets below four points: every point counts
      add_point(-32768, 32767, 1'b1);
      add_point(32767, -32768, 1'b0);
      add_point(0, 0, 1'b1);
      add_point(-32768, -32768, 1'b0);
      add_point(32767, -32768, 1'b0);
      add_point(0, 32767, 1'b1);
      // full-range square with its center: largest cross products
      add_point(-32768, -32768, 1'b0);
      add_point(32767, -32768, 1'b0);
      add_point(32767, 32767, 1'b0);
      add_point(-32768, 32767, 1'b0);
      add_point(0, 0, 1'b1);
      // point on an edge counts as inside
      add_point(0, 0, 1'b0);
      add_point(4, 0, 1'b0);
      add_point(0, 4, 1'b0);
      add_point(2, 0, 1'b1);
      // identical points
      add_point(-1, -1, 1'b0);
      add_point(-1, -1, 1'b0);
      add_point(-1, -1, 1'b0);
      add_point(-1, -1, 1'b1);
      // collinear points
      add_point(0, 0, 1'b0);
      add_point(1, 1, 1'b0);
      add_point(2, 2, 1'b0);
      add_point(3, 3, 1'b1);
      add_pause();

      // random sets, mostly small; a few fill the store, some past capacity
      set_no = 0;
      while (point_total < POINT_GOAL) begin
         set_no++;
         if (set_no % 50 == 25) begin
            add_flat_set(set_no == 25 ? bfh_pkg::MAX_POINTS + 2 :
                         $urandom_range(bfh_pkg::MAX_POINTS, bfh_pkg::MAX_POINTS + 4));
         end else begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
            add_random_set(n, coord_style_type'($urandom_range(0, 3)));
         end
         if ($urandom_range(0, 19) == 0)
            add_pause();
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      do
         @(posedge clock);
      while (point_queue.size() != 0 || req_if.valid || hull_expect.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // run limit
   initial begin
      #40_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
